/* design/lcdns_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and the step table for the character-LCD nibble sequencer.
// No dependencies; imported by every module of the block.
package lcdns_pkg;

	// request kinds as they arrive on the input channel
	localparam logic [2:0] KIND_INIT   = 3'd0;
	localparam logic [2:0] KIND_CMD    = 3'd1;
	localparam logic [2:0] KIND_CHAR   = 3'd2;
	localparam logic [2:0] KIND_CURSOR = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	// classified operations carried from front to back
	localparam logic [2:0] OP_INIT     = 3'd0;
	localparam logic [2:0] OP_BYTE     = 3'd1;
	localparam logic [2:0] OP_CLR_BYTE = 3'd2;
	localparam logic [2:0] OP_CLEAR    = 3'd3;
	localparam logic [2:0] OP_ERROR    = 3'd4;

	// configuration register indexes
	localparam logic REG_STROBE_HIGH   = 1'b0;
	localparam logic REG_STROBE_SETTLE = 1'b1;

	localparam logic [7:0] STROBE_HIGH_RST   = 8'd10;
	localparam logic [9:0] STROBE_SETTLE_RST = 10'd100;

	localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
	localparam logic [7:0] CMD_DISP_ON   = 8'h0E;
	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_ENTRY     = 8'h06;
	localparam logic [7:0] CMD_ROW1      = 8'h80;
	localparam logic [7:0] CMD_ROW2      = 8'hC0;
	localparam logic [3:0] NIB_WAKE      = 4'h3;
	localparam logic [3:0] NIB_4BIT      = 4'h2;
	localparam logic [15:0] WAIT_POWER   = 16'd60000;
	localparam logic [15:0] WAIT_WAKE1   = 16'd6000;
	localparam logic [15:0] WAIT_WAKE2   = 16'd150;
	localparam logic [15:0] WAIT_CLEAR   = 16'd2000;

	localparam int STEP_W     = 4;
	localparam int FIFO_DEPTH = 2;

	typedef struct packed {
		logic [2:0] op;
		logic       rs;
		logic [7:0] data;
	} op_t;

	typedef struct packed {
		logic        strobe_res;
		logic        rs;
		logic [3:0]  nibble;
		logic [15:0] wait_after_us;
		logic        error;
		logic        last;
	} res_t;

	function automatic res_t byte_step(logic rs, logic [7:0] b, logic lo,
			logic [15:0] wait_lo, logic fin);
		res_t r;
		r.strobe_res    = 1'b1;
		r.rs            = rs;
		r.nibble        = lo ? b[3:0] : b[7:4];
		r.wait_after_us = lo ? wait_lo : 16'd0;
		r.error         = 1'b0;
		r.last          = lo & fin;
		return r;
	endfunction

	function automatic res_t init_step(logic [STEP_W-1:0] step);
		res_t r;
		r = byte_step(1'b0, 8'h00, 1'b0, 16'd0, 1'b0);
		case (step)
			4'd0: begin
				r.strobe_res    = 1'b0;
				r.wait_after_us = WAIT_POWER;
			end
			4'd1: begin
				r.nibble        = NIB_WAKE;
				r.wait_after_us = WAIT_WAKE1;
			end
			4'd2: begin
				r.nibble        = NIB_WAKE;
				r.wait_after_us = WAIT_WAKE2;
			end
			4'd3: r.nibble = NIB_WAKE;
			4'd4: r.nibble = NIB_4BIT;
			4'd5: r.nibble = CMD_FUNC_SET[7:4];
			4'd6: r.nibble = CMD_FUNC_SET[3:0];
			4'd7: r.nibble = CMD_DISP_ON[7:4];
			4'd8: r.nibble = CMD_DISP_ON[3:0];
			4'd9: r.nibble = CMD_CLEAR[7:4];
			4'd10: begin
				r.nibble        = CMD_CLEAR[3:0];
				r.wait_after_us = WAIT_CLEAR;
			end
			4'd11: r.nibble = CMD_ENTRY[7:4];
			default: begin
				r.nibble = CMD_ENTRY[3:0];
				r.last   = 1'b1;
			end
		endcase
		return r;
	endfunction

	// one result of an operation at a given step
	function automatic res_t step_result(op_t o, logic [STEP_W-1:0] step);
		res_t r;
		r = '0;
		case (o.op)
			OP_INIT:  r = init_step(step);
			OP_BYTE:  r = byte_step(o.rs, o.data, step[0], 16'd0, 1'b1);
			OP_CLEAR: r = byte_step(1'b0, CMD_CLEAR, step[0], WAIT_CLEAR, 1'b1);
			OP_CLR_BYTE: begin
				if (step[1])
					r = byte_step(1'b0, o.data, step[0], 16'd0, 1'b1);
				else
					r = byte_step(1'b0, CMD_CLEAR, step[0], WAIT_CLEAR, 1'b0);
			end
			default: begin
				r.error = 1'b1;
				r.last  = 1'b1;
			end
		endcase
		return r;
	endfunction

endpackage

/* design/lcdns_front.sv */
`timescale 1ns / 1ps
// Front part: takes requests, classifies them into operations, holds one in a register.
// Depends on lcdns_pkg.
module lcdns_front
	import lcdns_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] kind,
	input  logic [7:0] value,
	input  logic [1:0] row,
	input  logic [5:0] column,
	input  logic       clear_first,
	output logic       push_valid,
	output op_t        push_entry,
	input  logic       push_ready
);

	logic       valid_s1;
	op_t        entry_s1;
	op_t        cls;
	logic       keep;
	logic [5:0] col_m1;
	logic       accept;

	assign col_m1 = column - 6'd1;

	always_comb begin
		cls      = '0;
		keep     = 1'b1;
		cls.op   = OP_BYTE;
		cls.data = value;
		case (kind)
			KIND_INIT: cls.op = OP_INIT;
			KIND_CMD:  cls.rs = 1'b0;
			KIND_CHAR: cls.rs = 1'b1;
			KIND_CURSOR: begin
				cls.data = ((row == 2'd1) ? CMD_ROW1 : CMD_ROW2) | {2'b00, col_m1};
				if (row == 2'd0 || column == 6'd0)
					cls.op = OP_ERROR;
				else if (row == 2'd3) begin
					cls.op = OP_CLEAR;
					keep   = clear_first;
				end else if (clear_first)
					cls.op = OP_CLR_BYTE;
			end
			KIND_CLEAR: cls.op = OP_CLEAR;
			default: keep = 1'b0;
		endcase
	end

	assign in_stall   = valid_s1 && !push_ready;
	assign accept     = in_valid && !in_stall;
	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || push_ready) begin
			valid_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (!valid_s1 || push_ready) begin
			entry_s1 <= cls;
		end
	end

endmodule

/* design/lcdns_fifo.sv */
`timescale 1ns / 1ps
// Short queue of classified operations between the front and back parts.
// Depends on lcdns_pkg.
module lcdns_fifo
	import lcdns_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  op_t  push_entry,
	output logic push_ready,
	output logic pop_valid,
	output op_t  pop_entry,
	input  logic pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

/* design/lcdns_back.sv */
`timescale 1ns / 1ps
// Back part: steps the head op into an output register, one nibble result per cycle unless stalled.
// Depends on lcdns_pkg.
module lcdns_back
	import lcdns_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	input  op_t  op_entry,
	output logic op_pop,
	output logic out_valid,
	input  logic out_stall,
	output res_t res
);

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	res_t              res_q;
	res_t              nxt;
	logic              load;

	assign nxt       = step_result(op_entry, step_q);
	assign load      = op_valid && (!out_valid_q || !out_stall);
	assign op_pop    = load && nxt.last;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				step_q <= nxt.last ? '0 : step_q + STEP_W'(1);
			if (!out_valid_q || !out_stall)
				out_valid_q <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= nxt;
	end

endmodule

/* design/char_lcd_nibble_sequencer_top.sv */
`timescale 1ns / 1ps
// Character-LCD nibble sequencer, top level. An input transfer passes the front register, queue
// and output register on its way to the first result. Throughput: one result per cycle unless
// stalled; an item yields 1 to 13 results, counted by the back-part step counter. Reset (arst_n
// low, asynchronous) empties those three and sets strobe timing to 10 us high, 100 us settle.
// Depends on lcdns_pkg, lcdns_front, lcdns_fifo, lcdns_back.
module char_lcd_nibble_sequencer_top
	import lcdns_pkg::*;
#(
	parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [9:0]  wr_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  value,
	input  logic [1:0]  row,
	input  logic [5:0]  column,
	input  logic        clear_first,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        strobe_res,
	output logic        rs,
	output logic [3:0]  nibble,
	output logic [15:0] wait_after_us,
	output logic        error,
	output logic        last
);

	// Strobe timing registers. Results carry only the extra wait per step; the
	// standard enable-high and settle times live here for the bus driver.
	logic [7:0] strobe_high_q;
	logic [9:0] strobe_settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_high_q   <= STROBE_HIGH_RST;
			strobe_settle_q <= STROBE_SETTLE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_STROBE_HIGH:   strobe_high_q   <= wr_data[7:0];
				REG_STROBE_SETTLE: strobe_settle_q <= wr_data;
				default: ;
			endcase
		end
	end

	logic push_valid;
	logic push_ready;
	op_t  push_entry;
	logic pop_valid;
	logic pop;
	op_t  pop_entry;
	res_t res;

	// Classify each transfer; requests that produce nothing are dropped here.
	lcdns_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.value       (value),
		.row         (row),
		.column      (column),
		.clear_first (clear_first),
		.push_valid  (push_valid),
		.push_entry  (push_entry),
		.push_ready  (push_ready)
	);

	// Decouple the two sides so the front keeps accepting while the back expands.
	lcdns_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop        (pop)
	);

	// Expand the head operation into its ordered nibble strobes.
	lcdns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (pop_valid),
		.op_entry  (pop_entry),
		.op_pop    (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign strobe_res    = res.strobe_res;
	assign rs            = res.rs;
	assign nibble        = res.nibble;
	assign wait_after_us = res.wait_after_us;
	assign error         = res.error;
	assign last          = res.last;

endmodule

/* tb/sv/char_lcd_nibble_sequencer_checker.sv */
`timescale 1ns / 1ps
// Checker for the character-LCD nibble sequencer: watches both channels and the register port,
// expands each accepted request into its strobe list and compares results in order.
// Depends on lcdns_pkg for the request codes, command constants and the result struct.
module char_lcd_nibble_sequencer_checker
	import lcdns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [9:0]  wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  value,
	input  logic [1:0]  row,
	input  logic [5:0]  column,
	input  logic        clear_first,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        strobe_res,
	input  logic        rs,
	input  logic [3:0]  nibble,
	input  logic [15:0] wait_after_us,
	input  logic        error,
	input  logic        last,
	output int          mismatches,
	output int          pending
);

	res_t strobe_q[$];

	// timing registers shadowed here; they set bus timing only and never show in a result
	logic [7:0] high_time_us;
	logic [9:0] settle_time_us;

	function automatic void push_step(logic strb, logic sel, logic [3:0] nib,
			logic [15:0] hold_us, logic err);
		res_t r;
		r.strobe_res    = strb;
		r.rs            = sel;
		r.nibble        = nib;
		r.wait_after_us = hold_us;
		r.error         = err;
		r.last          = 1'b0;
		strobe_q.push_back(r);
	endfunction

	// high nibble first, the extra wait rides on the low nibble
	function automatic void push_byte(logic sel, logic [7:0] b, logic [15:0] hold_us);
		push_step(1'b1, sel, b[7:4], 16'd0, 1'b0);
		push_step(1'b1, sel, b[3:0], hold_us, 1'b0);
	endfunction

	function automatic void expand_request(logic [2:0] k, logic [7:0] v, logic [1:0] r,
			logic [5:0] c, logic cf);
		int   base;
		res_t tail;
		base = strobe_q.size();
		case (k)
			KIND_INIT: begin
				push_step(1'b0, 1'b0, 4'h0, WAIT_POWER, 1'b0);
				push_step(1'b1, 1'b0, NIB_WAKE, WAIT_WAKE1, 1'b0);
				push_step(1'b1, 1'b0, NIB_WAKE, WAIT_WAKE2, 1'b0);
				push_step(1'b1, 1'b0, NIB_WAKE, 16'd0, 1'b0);
				push_step(1'b1, 1'b0, NIB_4BIT, 16'd0, 1'b0);
				push_byte(1'b0, CMD_FUNC_SET, 16'd0);
				push_byte(1'b0, CMD_DISP_ON, 16'd0);
				push_byte(1'b0, CMD_CLEAR, WAIT_CLEAR);
				push_byte(1'b0, CMD_ENTRY, 16'd0);
			end
			KIND_CMD:  push_byte(1'b0, v, 16'd0);
			KIND_CHAR: push_byte(1'b1, v, 16'd0);
			KIND_CURSOR: begin
				if (r == 2'd0 || c == 6'd0) begin
					push_step(1'b0, 1'b0, 4'h0, 16'd0, 1'b1);
				end else begin
					if (cf)
						push_byte(1'b0, CMD_CLEAR, WAIT_CLEAR);
					if (r == 2'd1)
						push_byte(1'b0, CMD_ROW1 | {2'b00, c - 6'd1}, 16'd0);
					else if (r == 2'd2)
						push_byte(1'b0, CMD_ROW2 | {2'b00, c - 6'd1}, 16'd0);
				end
			end
			KIND_CLEAR: push_byte(1'b0, CMD_CLEAR, WAIT_CLEAR);
			default: ;
		endcase
		if (strobe_q.size() > base) begin
			tail      = strobe_q.pop_back();
			tail.last = 1'b1;
			strobe_q.push_back(tail);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t seen;
		res_t want;
		if (!arst_n) begin
			strobe_q.delete();
			high_time_us   = STROBE_HIGH_RST;
			settle_time_us = STROBE_SETTLE_RST;
			mismatches     = 0;
			pending        = 0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_STROBE_HIGH)
					high_time_us = wr_data[7:0];
				else
					settle_time_us = wr_data;
			end
			if (in_valid && !in_stall)
				expand_request(kind, value, row, column, clear_first);
			if (out_valid && !out_stall) begin
				seen = '{strobe_res, rs, nibble, wait_after_us, error, last};
				if (strobe_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with nothing expected: str=%0d rs=%0d nib=%h wait=%0d err=%0d last=%0d",
							$realtime, strobe_res, rs, nibble, wait_after_us, error, last);
				end else begin
					want = strobe_q.pop_front();
					if (seen != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch exp str=%0d rs=%0d nib=%h wait=%0d err=%0d last=%0d | got str=%0d rs=%0d nib=%h wait=%0d err=%0d last=%0d",
								$realtime, want.strobe_res, want.rs, want.nibble,
								want.wait_after_us, want.error, want.last,
								seen.strobe_res, seen.rs, seen.nibble,
								seen.wait_after_us, seen.error, seen.last);
					end
				end
			end
			pending = strobe_q.size();
		end
	end

endmodule

/* tb/sv/char_lcd_nibble_sequencer_top_test.sv */
`timescale 1ns / 1ps
// Top of the nibble sequencer testbench: clock, reset, register writes, request traffic
// and result back-pressure; the verdict comes from the checker's mismatch count.
// Depends on lcdns_pkg, char_lcd_nibble_sequencer_top and char_lcd_nibble_sequencer_checker.
module char_lcd_nibble_sequencer_top_test;
	import lcdns_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic        wr_index;
	logic [9:0]  wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  kind;
	logic [7:0]  value;
	logic [1:0]  row;
	logic [5:0]  column;
	logic        clear_first;
	logic        out_valid;
	logic        out_stall;
	logic        strobe_res;
	logic        rs;
	logic [3:0]  nibble;
	logic [15:0] wait_after_us;
	logic        error;
	logic        last;

	int mismatches;
	int pending;
	int cycles;

	// odds in percent that a sender gap or a receiver stall burst starts at a given point
	int gap_odds;
	int stall_odds;

	char_lcd_nibble_sequencer_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.value         (value),
		.row           (row),
		.column        (column),
		.clear_first   (clear_first),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.strobe_res    (strobe_res),
		.rs            (rs),
		.nibble        (nibble),
		.wait_after_us (wait_after_us),
		.error         (error),
		.last          (last)
	);

	char_lcd_nibble_sequencer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.value         (value),
		.row           (row),
		.column        (column),
		.clear_first   (clear_first),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.strobe_res    (strobe_res),
		.rs            (rs),
		.nibble        (nibble),
		.wait_after_us (wait_after_us),
		.error         (error),
		.last          (last),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("char_lcd_nibble_sequencer_top_test: done, errors");
				$finish;
			end
		end
	end

	// Result side back-pressure: raise stall in bursts, changed only at the falling edge.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_odds > 0 && $urandom_range(0, 99) < stall_odds) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Write one timing register; call only at a falling edge while the block is idle.
	task automatic write_reg(logic idx, logic [9:0] data);
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = data;
		@(negedge clk);
		wr_en    = 1'b0;
	endtask

	// Hold the sender until every expected result is out, then give the block time to
	// finish requests that cause no result at all.
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Present one request and hold it until the transfer; returns at a falling edge with
	// valid still high, so back-to-back requests keep valid asserted.
	task automatic send_request(logic [2:0] k, logic [7:0] v, logic [1:0] r, logic [5:0] c,
			logic cf);
		if (gap_odds > 0 && $urandom_range(0, 99) < gap_odds) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		kind        = k;
		value       = v;
		row         = r;
		column      = c;
		clear_first = cf;
		in_valid    = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Random request mix: mostly bytes, characters and cursor moves, with the long init
	// sequence, clears and ignored kinds now and then. Returns 1 if the kind is a real one.
	task automatic random_request(output bit counted);
		int          pick;
		logic [2:0]  k;
		logic [5:0]  c;
		pick = $urandom_range(0, 99);
		if (pick < 5)       k = KIND_INIT;
		else if (pick < 30) k = KIND_CMD;
		else if (pick < 55) k = KIND_CHAR;
		else if (pick < 85) k = KIND_CURSOR;
		else if (pick < 93) k = KIND_CLEAR;
		else                k = 3'($urandom_range(5, 7));
		// zero column is the error case; keep it rare but present
		c = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
		send_request(k, 8'($urandom), 2'($urandom_range(0, 3)), c, 1'($urandom));
		counted = (k <= KIND_CLEAR);
	endtask

	task automatic random_phase(int items);
		int n;
		bit counted;
		n = 0;
		while (n < items) begin
			random_request(counted);
			if (counted) n++;
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		wr_en       = 1'b0;
		wr_index    = REG_STROBE_HIGH;
		wr_data     = '0;
		in_valid    = 1'b0;
		kind        = KIND_INIT;
		value       = '0;
		row         = '0;
		column      = '0;
		clear_first = 1'b0;
		gap_odds    = 25;
		stall_odds  = 15;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pass at reset timing: every kind, byte extremes, the cursor
		// error cases, row three with and without clear, and the ignored kinds.
		send_request(KIND_INIT,   8'h00, 2'd0, 6'd0,  1'b0);
		send_request(KIND_CMD,    8'h00, 2'd0, 6'd0,  1'b0);
		send_request(KIND_CMD,    8'hFF, 2'd3, 6'd63, 1'b1);
		send_request(KIND_CHAR,   8'h00, 2'd0, 6'd0,  1'b0);
		send_request(KIND_CHAR,   8'hFF, 2'd0, 6'd0,  1'b0);
		send_request(KIND_CHAR,   8'hA5, 2'd1, 6'd1,  1'b1);
		send_request(KIND_CURSOR, 8'h00, 2'd0, 6'd5,  1'b0);
		send_request(KIND_CURSOR, 8'h00, 2'd1, 6'd0,  1'b1);
		send_request(KIND_CURSOR, 8'hFF, 2'd0, 6'd0,  1'b1);
		send_request(KIND_CURSOR, 8'h00, 2'd1, 6'd1,  1'b0);
		send_request(KIND_CURSOR, 8'h00, 2'd1, 6'd63, 1'b1);
		send_request(KIND_CURSOR, 8'h00, 2'd2, 6'd1,  1'b0);
		send_request(KIND_CURSOR, 8'hFF, 2'd2, 6'd63, 1'b1);
		send_request(KIND_CURSOR, 8'h00, 2'd3, 6'd10, 1'b1);
		send_request(KIND_CURSOR, 8'h00, 2'd3, 6'd10, 1'b0);
		send_request(KIND_CLEAR,  8'h5A, 2'd2, 6'd42, 1'b1);
		send_request(3'd5,        8'hFF, 2'd3, 6'd63, 1'b1);
		send_request(3'd6,        8'h00, 2'd1, 6'd1,  1'b0);
		send_request(3'd7,        8'h81, 2'd2, 6'd2,  1'b1);
		send_request(KIND_INIT,   8'hFF, 2'd3, 6'd63, 1'b1);
		drain();

		// Timing at its lower extremes, heavy idling on both sides.
		write_reg(REG_STROBE_HIGH, 10'd1);
		write_reg(REG_STROBE_SETTLE, 10'd1);
		gap_odds   = 40;
		stall_odds = 30;
		random_phase(60);
		drain();

		// Timing at its upper extremes, no idling at all.
		write_reg(REG_STROBE_HIGH, 10'd255);
		write_reg(REG_STROBE_SETTLE, 10'd1023);
		gap_odds   = 0;
		stall_odds = 0;
		random_phase(60);
		drain();

		// Random timing, light idling.
		write_reg(REG_STROBE_HIGH, 10'($urandom_range(1, 255)));
		write_reg(REG_STROBE_SETTLE, 10'($urandom_range(1, 1023)));
		gap_odds   = 10;
		stall_odds = 8;
		random_phase(60);
		drain();

		// Back to reset timing; the closing stretch runs with no idling.
		write_reg(REG_STROBE_HIGH, 10'(STROBE_HIGH_RST));
		write_reg(REG_STROBE_SETTLE, STROBE_SETTLE_RST);
		gap_odds   = 20;
		stall_odds = 20;
		random_phase(25);
		gap_odds   = 0;
		stall_odds = 0;
		random_phase(25);
		drain();

		if (mismatches == 0 && pending == 0) begin
			$display("char_lcd_nibble_sequencer_top_test: done, clean");
		end else begin
			$display("char_lcd_nibble_sequencer_top_test: done, errors");
		end
		$finish;
	end

endmodule
